// File: rtl/lpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpw_pkg
// Shared types, codes and helpers for the line pixel walker.
// ----------------------------------------------------------------------------
package lpw_pkg;

  localparam int COORD_W = 9;
  localparam int ERR_W   = 11;
  localparam int COLOR_W = 16;
  localparam int CFG_IDX_W = 2;

  // panel height in rows, used for the landscape page flip
  localparam int SCREEN_ROWS = 480;
  localparam logic [COORD_W-1:0] ROWS_M1 = COORD_W'((SCREEN_ROWS - 1) % (1 << COORD_W));

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [COLOR_W-1:0] color_t;

  // input word commands
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIENTATION = 2'd0,
    REG_DRAW_COLOR  = 2'd1,
    REG_SPARE_2     = 2'd2,
    REG_SPARE_3     = 2'd3
  } cfg_reg_t;

  localparam color_t DRAW_COLOR_RST = 16'hFFFF;

  typedef struct packed {
    logic   command;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_word_t;

  typedef struct packed {
    coord_t panel_column;
    coord_t panel_page;
    color_t pixel_color;
    logic   last_pixel;
  } out_word_t;

  // result handoff from walker to output stage
  typedef struct packed {
    logic      emit;
    out_word_t word;
  } result_t;

  // one step along an axis, wrapping in nine bits
  function automatic coord_t step_coord(input coord_t v, input logic down);
    step_coord = down ? (v - coord_t'(1)) : (v + coord_t'(1));
  endfunction

endpackage

// File: rtl/lpw_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpw_walker
// Line state and one error-term update per accepted step word.
// ----------------------------------------------------------------------------
module lpw_walker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  lpw_pkg::in_word_t  in_word,
  input  logic               orientation,
  input  lpw_pkg::color_t    draw_color,
  output lpw_pkg::result_t   result
);

  lpw_pkg::coord_t cursor_x_r, cursor_x_nxt;
  lpw_pkg::coord_t cursor_y_r, cursor_y_nxt;
  lpw_pkg::coord_t target_x_r, target_x_nxt;
  lpw_pkg::coord_t target_y_r, target_y_nxt;
  lpw_pkg::coord_t delta_x_r, delta_x_nxt;
  lpw_pkg::coord_t delta_y_r, delta_y_nxt;
  lpw_pkg::err_t   error_term_r, error_term_nxt;
  logic            x_decreasing_r, x_decreasing_nxt;
  logic            y_decreasing_r, y_decreasing_nxt;
  logic            y_major_r, y_major_nxt;
  logic            line_active_r, line_active_nxt;

  lpw_pkg::coord_t sx, sy, ex, ey;
  lpw_pkg::coord_t dx_ld, dy_ld, dmaj_ld;
  logic            ymaj_ld;
  lpw_pkg::err_t   err_sum;
  logic            is_last;

  assign sx = in_word.start_x;
  assign sy = in_word.start_y;
  assign ex = in_word.end_x;
  assign ey = in_word.end_y;

  // spans of a freshly loaded line
  assign dx_ld = (sx > ex) ? (sx - ex) : (ex - sx);
  assign dy_ld = (sy > ey) ? (sy - ey) : (ey - sy);
  assign ymaj_ld = (sy == ey) ? 1'b0 : ((sx == ex) ? 1'b1 : (dx_ld < dy_ld));
  assign dmaj_ld = ymaj_ld ? dy_ld : dx_ld;

  // error accumulate with the minor span
  assign err_sum = error_term_r
                 + lpw_pkg::err_t'({2'b00, (y_major_r ? delta_x_r : delta_y_r)});

  assign is_last = y_major_r ? (cursor_y_r == target_y_r) : (cursor_x_r == target_x_r);

  // current pixel in panel coordinates
  always_comb begin
    result.emit              = 1'b0;
    result.word.pixel_color  = draw_color;
    result.word.last_pixel   = is_last;
    if (orientation) begin
      result.word.panel_column = cursor_y_r;
      result.word.panel_page   = lpw_pkg::ROWS_M1 - cursor_x_r;
    end else begin
      result.word.panel_column = cursor_x_r;
      result.word.panel_page   = cursor_y_r;
    end
    if (accept && (in_word.command == lpw_pkg::CMD_STEP) && line_active_r) begin
      result.emit = 1'b1;
    end
  end

  // next line state
  always_comb begin
    cursor_x_nxt     = cursor_x_r;
    cursor_y_nxt     = cursor_y_r;
    target_x_nxt     = target_x_r;
    target_y_nxt     = target_y_r;
    delta_x_nxt      = delta_x_r;
    delta_y_nxt      = delta_y_r;
    error_term_nxt   = error_term_r;
    x_decreasing_nxt = x_decreasing_r;
    y_decreasing_nxt = y_decreasing_r;
    y_major_nxt      = y_major_r;
    line_active_nxt  = line_active_r;
    if (accept) begin
      if (in_word.command == lpw_pkg::CMD_LOAD) begin
        x_decreasing_nxt = 1'b0;
        y_decreasing_nxt = 1'b0;
        delta_x_nxt      = dx_ld;
        delta_y_nxt      = dy_ld;
        y_major_nxt      = ymaj_ld;
        line_active_nxt  = 1'b1;
        error_term_nxt   = -lpw_pkg::err_t'({3'b000, dmaj_ld[lpw_pkg::COORD_W-1:1]});
        if (sy == ey) begin
          // horizontal: walk from the lower x
          cursor_x_nxt = (sx < ex) ? sx : ex;
          target_x_nxt = (sx < ex) ? ex : sx;
          cursor_y_nxt = sy;
          target_y_nxt = sy;
          delta_y_nxt  = '0;
        end else if (sx == ex) begin
          // vertical: walk from the lower y
          cursor_y_nxt = (sy < ey) ? sy : ey;
          target_y_nxt = (sy < ey) ? ey : sy;
          cursor_x_nxt = sx;
          target_x_nxt = sx;
          delta_x_nxt  = '0;
        end else begin
          cursor_x_nxt     = sx;
          cursor_y_nxt     = sy;
          target_x_nxt     = ex;
          target_y_nxt     = ey;
          x_decreasing_nxt = (ex < sx);
          y_decreasing_nxt = (ey < sy);
        end
      end else if (line_active_r) begin
        if (is_last) begin
          line_active_nxt = 1'b0;
        end else if (y_major_r) begin
          cursor_y_nxt = lpw_pkg::step_coord(cursor_y_r, y_decreasing_r);
          if (delta_x_r != '0) begin
            if (!err_sum[lpw_pkg::ERR_W-1]) begin
              cursor_x_nxt   = lpw_pkg::step_coord(cursor_x_r, x_decreasing_r);
              error_term_nxt = err_sum - lpw_pkg::err_t'({2'b00, delta_y_r});
            end else begin
              error_term_nxt = err_sum;
            end
          end
        end else begin
          cursor_x_nxt = lpw_pkg::step_coord(cursor_x_r, x_decreasing_r);
          if (delta_y_r != '0) begin
            if (!err_sum[lpw_pkg::ERR_W-1]) begin
              cursor_y_nxt   = lpw_pkg::step_coord(cursor_y_r, y_decreasing_r);
              error_term_nxt = err_sum - lpw_pkg::err_t'({2'b00, delta_x_r});
            end else begin
              error_term_nxt = err_sum;
            end
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r     <= '0;
      cursor_y_r     <= '0;
      target_x_r     <= '0;
      target_y_r     <= '0;
      delta_x_r      <= '0;
      delta_y_r      <= '0;
      error_term_r   <= '0;
      x_decreasing_r <= 1'b0;
      y_decreasing_r <= 1'b0;
      y_major_r      <= 1'b0;
      line_active_r  <= 1'b0;
    end else begin
      cursor_x_r     <= cursor_x_nxt;
      cursor_y_r     <= cursor_y_nxt;
      target_x_r     <= target_x_nxt;
      target_y_r     <= target_y_nxt;
      delta_x_r      <= delta_x_nxt;
      delta_y_r      <= delta_y_nxt;
      error_term_r   <= error_term_nxt;
      x_decreasing_r <= x_decreasing_nxt;
      y_decreasing_r <= y_decreasing_nxt;
      y_major_r      <= y_major_nxt;
      line_active_r  <= line_active_nxt;
    end
  end

  // a load always starts a line
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_word.command == lpw_pkg::CMD_LOAD) |=> line_active_r)
    else $error("load did not start a line");

  // the final pixel ends the line
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    result.emit && result.word.last_pixel |=> !line_active_r)
    else $error("line still active after last pixel");

  // pixels only come from an active line
  a_emit_active: assert property (@(posedge clk) disable iff (!rst_n)
    result.emit |-> line_active_r && accept)
    else $error("pixel emitted without an active line");

endmodule

// File: rtl/lpw_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpw_out_stage
// Result register between the walker and the output channel.
// ----------------------------------------------------------------------------
module lpw_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  lpw_pkg::result_t   result,
  input  logic               out_stall,
  output logic               out_valid,
  output lpw_pkg::out_word_t out_word,
  output logic               in_stall
);

  logic               out_valid_r;
  lpw_pkg::out_word_t out_word_r;

  // hold the input back only while a finished word waits on a stalled sink
  assign in_stall  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (result.emit) begin
      out_word_r <= result.word;
    end
  end

  // a new word never lands on a stalled one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    result.emit |-> !(out_valid_r && out_stall))
    else $error("result overwrote a stalled word");

  // an emitted word shows up the next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    result.emit |=> out_valid_r && (out_word_r == $past(result.word)))
    else $error("emitted word missing from output register");

  // output drops only after being taken
  a_drop_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> !$past(out_stall))
    else $error("output word lost while stalled");

endmodule

// File: rtl/line_pixel_walker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pixel_walker_top
// Rasterizes a line into panel pixel addresses, one pixel per step word.
// ----------------------------------------------------------------------------
// The walker takes one input word per clock. A load word latches the two
// endpoints and emits nothing; each step word while a line is active emits
// one pixel (column, page, color, last flag), which appears in the output
// register in the cycle after the step is taken. The rate is one pixel per
// clock, set by the single error-term add and compare done per step. Input
// is stalled only while a finished word sits in the output register and the
// sink stalls. Configuration writes are taken in any cycle (cfg_ready is
// always high); indexes beyond the two registers are ignored.
module line_pixel_walker_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lpw_pkg::in_word_t                in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lpw_pkg::out_word_t               out_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lpw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lpw_pkg::COLOR_W-1:0]      cfg_data
);

  logic             orientation_r;
  lpw_pkg::color_t  draw_color_r;
  logic             in_accept;
  lpw_pkg::result_t result;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orientation_r <= 1'b0;
      draw_color_r  <= lpw_pkg::DRAW_COLOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lpw_pkg::cfg_reg_t'(cfg_index))
        lpw_pkg::REG_ORIENTATION: orientation_r <= cfg_data[0];
        lpw_pkg::REG_DRAW_COLOR:  draw_color_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  lpw_walker u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .in_word     (in_word),
    .orientation (orientation_r),
    .draw_color  (draw_color_r),
    .result      (result)
  );

  lpw_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .in_stall  (in_stall)
  );

endmodule

// File: test/tb_line_pixel_walker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_pixel_walker_top
// Self-checking bench for the line pixel walker. A walk model inside the bench
// follows every accepted load and step word and predicts each emitted pixel.
// A directed table (points, reversed horizontal and vertical lines, ties,
// steep lines, reload mid-line, landscape flip, color extremes, ignored
// register index) is followed by random phases of lines with random stalls.
// ----------------------------------------------------------------------------
module tb_line_pixel_walker_top;

  localparam int HALF_PERIOD   = 4;
  localparam int MAX_COORD     = 479;
  localparam int RANDOM_WORDS  = 1300;
  localparam int PHASES        = 10;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 150;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int ERROR_PRINTS  = 25;

  typedef enum bit {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    lpw_pkg::in_word_t  word;
    lpw_pkg::cfg_reg_t  reg_idx;
    lpw_pkg::color_t    reg_data;
    bit                 typed;
    lpw_pkg::out_word_t pixel;
  } plan_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  lpw_pkg::in_word_t             in_word;
  logic                          out_valid;
  logic                          out_stall;
  lpw_pkg::out_word_t            out_word;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [lpw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lpw_pkg::COLOR_W-1:0]   cfg_data;

  line_pixel_walker_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // walk model state and register copies
  lpw_pkg::coord_t cur_x, cur_y, tgt_x, tgt_y, span_x, span_y;
  int              err_acc;
  bit              x_down, y_down, steep, walking;
  bit              land_mode;
  lpw_pkg::color_t ink;

  lpw_pkg::out_word_t expected_pixels[$];
  plan_row_t          plan_rows[$];

  int mismatches;
  int cycle_count;
  int pixels_checked;
  int words_sent;
  int useful_words;
  int lines_loaded;
  int reg_writes;
  int gap_pct;
  int stall_pct;

  // clock
  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding",
               cycle_count, expected_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // predict one accepted word; returns 1 when a pixel comes out
  function automatic bit walk_word(input lpw_pkg::in_word_t w,
                                   output lpw_pkg::out_word_t px);
    lpw_pkg::coord_t dx, dy;
    bit              at_end;
    px = '0;
    dx = (w.start_x > w.end_x) ? w.start_x - w.end_x : w.end_x - w.start_x;
    dy = (w.start_y > w.end_y) ? w.start_y - w.end_y : w.end_y - w.start_y;
    // load: latch endpoints, horizontal and vertical walked from the low end
    if (w.command == lpw_pkg::CMD_LOAD) begin
      x_down = 1'b0;
      y_down = 1'b0;
      if (w.start_y == w.end_y) begin
        cur_x  = (w.start_x < w.end_x) ? w.start_x : w.end_x;
        tgt_x  = (w.start_x < w.end_x) ? w.end_x : w.start_x;
        cur_y  = w.start_y;
        tgt_y  = w.start_y;
        span_x = dx;
        span_y = '0;
        steep  = 1'b0;
      end else if (w.start_x == w.end_x) begin
        cur_y  = (w.start_y < w.end_y) ? w.start_y : w.end_y;
        tgt_y  = (w.start_y < w.end_y) ? w.end_y : w.start_y;
        cur_x  = w.start_x;
        tgt_x  = w.start_x;
        span_x = '0;
        span_y = dy;
        steep  = 1'b1;
      end else begin
        cur_x  = w.start_x;
        cur_y  = w.start_y;
        tgt_x  = w.end_x;
        tgt_y  = w.end_y;
        span_x = dx;
        span_y = dy;
        x_down = w.end_x < w.start_x;
        y_down = w.end_y < w.start_y;
        steep  = dx < dy;
      end
      err_acc = steep ? -int'(span_y >> 1) : -int'(span_x >> 1);
      walking = 1'b1;
      return 1'b0;
    end
    // step with no line in progress does nothing
    if (!walking) return 1'b0;
    at_end = steep ? (cur_y == tgt_y) : (cur_x == tgt_x);
    px.panel_column = land_mode ? cur_y : cur_x;
    px.panel_page   = land_mode ?
                      lpw_pkg::coord_t'(lpw_pkg::SCREEN_ROWS - 1 - int'(cur_x)) : cur_y;
    px.pixel_color  = ink;
    px.last_pixel   = at_end;
    if (at_end) begin
      walking = 1'b0;
    end else if (steep) begin
      cur_y = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
      if (span_x != 0) begin
        err_acc += int'(span_x);
        if (err_acc >= 0) begin
          cur_x = x_down ? cur_x - 1'b1 : cur_x + 1'b1;
          err_acc -= int'(span_y);
        end
      end
    end else begin
      cur_x = x_down ? cur_x - 1'b1 : cur_x + 1'b1;
      if (span_y != 0) begin
        err_acc += int'(span_y);
        if (err_acc >= 0) begin
          cur_y = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
          err_acc -= int'(span_x);
        end
      end
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      if (mismatches < ERROR_PRINTS)
        $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // output checker
  always @(posedge clk) begin
    lpw_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
        if (mismatches < ERROR_PRINTS)
          $error("pixel col %0d page %0d with none expected",
                 out_word.panel_column, out_word.panel_page);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("panel_column", want.panel_column, out_word.panel_column);
        check_field("panel_page", want.panel_page, out_word.panel_page);
        check_field("pixel_color", want.pixel_color, out_word.pixel_color);
        check_field("last_pixel", want.last_pixel, out_word.last_pixel);
      end
    end
  end

  // sink: random stall runs, plus two long holds while the source keeps going
  initial begin
    int  run;
    int  holds_done;
    bit  stall_val;
    holds_done = 0;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_done < 2 && pixels_checked >= 200 + 600 * holds_done) begin
        stall_val = 1'b1;
        run = LONG_HOLD;
        holds_done++;
      end else if (stall_pct == 0) begin
        stall_val = 1'b0;
        run = $urandom_range(1, 8);
      end else begin
        stall_val = $urandom_range(0, 99) < stall_pct;
        if (stall_val)
          run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        else
          run = $urandom_range(1, 6);
      end
      out_stall <= stall_val;
      repeat (run) @(posedge clk);
    end
  end

  // drive one word, wait for acceptance, then predict
  task automatic send_word(input lpw_pkg::in_word_t w, input bit typed,
                           input lpw_pkg::out_word_t typed_px);
    lpw_pkg::out_word_t px;
    bit                 emits;
    int                 gap;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    emits = walk_word(w, px);
    words_sent++;
    if (w.command == lpw_pkg::CMD_LOAD) lines_loaded++;
    if (w.command == lpw_pkg::CMD_LOAD || emits) useful_words++;
    if (typed) expected_pixels.push_back(typed_px);
    else if (emits) expected_pixels.push_back(px);
  endtask

  // hold the source until every pixel is out and the walker is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_valid stays high; the caller lowers it after the last write
  task automatic write_reg(input lpw_pkg::cfg_reg_t idx, input lpw_pkg::color_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lpw_pkg::REG_ORIENTATION: land_mode = data[0];
      lpw_pkg::REG_DRAW_COLOR:  ink = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic int pick_coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? MAX_COORD : 0;
    return $urandom_range(0, MAX_COORD);
  endfunction

  function automatic int pick_near(input int c, input int reach);
    int lo, hi;
    lo = (c - reach < 0) ? 0 : c - reach;
    hi = (c + reach > MAX_COORD) ? MAX_COORD : c + reach;
    return $urandom_range(hi, lo);
  endfunction

  function automatic lpw_pkg::in_word_t random_word(input lpw_pkg::cmd_t c);
    lpw_pkg::in_word_t w;
    w.command = c;
    w.start_x = lpw_pkg::coord_t'(pick_coord());
    w.start_y = lpw_pkg::coord_t'(pick_coord());
    w.end_x   = lpw_pkg::coord_t'(pick_coord());
    w.end_y   = lpw_pkg::coord_t'(pick_coord());
    return w;
  endfunction

  // directed table builders
  function automatic plan_row_t word_row(input lpw_pkg::cmd_t c, input int sx, input int sy,
                                          input int ex, input int ey);
    plan_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.word = '{c, lpw_pkg::coord_t'(sx), lpw_pkg::coord_t'(sy),
               lpw_pkg::coord_t'(ex), lpw_pkg::coord_t'(ey)};
    return r;
  endfunction

  function automatic plan_row_t pixel_row(input int col, input int page,
                                           input lpw_pkg::color_t c, input bit last);
    plan_row_t r;
    r = word_row(lpw_pkg::CMD_STEP, 0, 0, 0, 0);
    r.typed = 1'b1;
    r.pixel = '{lpw_pkg::coord_t'(col), lpw_pkg::coord_t'(page), c, last};
    return r;
  endfunction

  function automatic plan_row_t reg_row(input lpw_pkg::cfg_reg_t idx,
                                         input lpw_pkg::color_t data);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_data = data;
    return r;
  endfunction

  // one load followed by its steps; some cut short, some with idle steps after
  task automatic draw_random_line();
    int                shape, reach, sx, sy, ex, ey, d, adx, ady, pixels, steps, pick;
    lpw_pkg::in_word_t w;
    shape = $urandom_range(0, 99);
    reach = ($urandom_range(0, 99) < 4) ? MAX_COORD :
            (($urandom_range(0, 99) < 30) ? 40 : 10);
    sx = pick_coord();
    sy = pick_coord();
    ex = pick_near(sx, reach);
    ey = pick_near(sy, reach);
    if (shape < 8) begin
      ex = sx;
      ey = sy;
    end else if (shape < 22) begin
      ey = sy;
    end else if (shape < 36) begin
      ex = sx;
    end else if (shape < 46) begin
      // equal spans, walked as x-major
      d  = $urandom_range(0, (reach < 239) ? reach : 239);
      ex = ($urandom_range(0, 1) && sx >= d) ? sx - d : ((sx + d <= MAX_COORD) ? sx + d : sx - d);
      ey = ($urandom_range(0, 1) && sy >= d) ? sy - d : ((sy + d <= MAX_COORD) ? sy + d : sy - d);
    end
    adx = (ex > sx) ? ex - sx : sx - ex;
    ady = (ey > sy) ? ey - sy : sy - ey;
    pixels = ((adx > ady) ? adx : ady) + 1;
    pick = $urandom_range(0, 9);
    if (pick == 0) steps = $urandom_range(0, pixels - 1);
    else if (pick == 1) steps = pixels + $urandom_range(1, 2);
    else steps = pixels;
    w = random_word(lpw_pkg::CMD_LOAD);
    w.start_x = lpw_pkg::coord_t'(sx);
    w.start_y = lpw_pkg::coord_t'(sy);
    w.end_x   = lpw_pkg::coord_t'(ex);
    w.end_y   = lpw_pkg::coord_t'(ey);
    send_word(w, 1'b0, '0);
    repeat (steps) send_word(random_word(lpw_pkg::CMD_STEP), 1'b0, '0);
  endtask

  // main sequence
  initial begin
    int              phase;
    int              target;
    bit              orient;
    lpw_pkg::color_t color;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cur_x = '0; cur_y = '0; tgt_x = '0; tgt_y = '0; span_x = '0; span_y = '0;
    err_acc = 0;
    x_down = 1'b0; y_down = 1'b0; steep = 1'b0; walking = 1'b0;
    land_mode = 1'b0;
    ink = lpw_pkg::DRAW_COLOR_RST;
    gap_pct = 30;
    stall_pct = 30;

    // directed table
    plan_rows.push_back(word_row(lpw_pkg::CMD_STEP, 0, 0, 0, 0));   // step while idle
    plan_rows.push_back(word_row(lpw_pkg::CMD_LOAD, 5, 7, 5, 7));   // single point
    plan_rows.push_back(pixel_row(5, 7, 16'hFFFF, 1'b1));
    plan_rows.push_back(word_row(lpw_pkg::CMD_LOAD, MAX_COORD, MAX_COORD,
                                 MAX_COORD, MAX_COORD));
    plan_rows.push_back(pixel_row(MAX_COORD, MAX_COORD, 16'hFFFF, 1'b1));
    plan_rows.push_back(word_row(lpw_pkg::CMD_LOAD, 12, 3, 9, 3));  // horizontal, reversed
    plan_rows.push_back(pixel_row(9, 3, 16'hFFFF, 1'b0));
    plan_rows.push_back(pixel_row(10, 3, 16'hFFFF, 1'b0));
    plan_rows.push_back(pixel_row(11, 3, 16'hFFFF, 1'b0));
    plan_rows.push_back(pixel_row(12, 3, 16'hFFFF, 1'b1));
    plan_rows.push_back(word_row(lpw_pkg::CMD_STEP, 0, 0, 0, 0));   // idle again
    plan_rows.push_back(word_row(lpw_pkg::CMD_LOAD, 4, 20, 4, 18)); // vertical, reversed
    plan_rows.push_back(pixel_row(4, 18, 16'hFFFF, 1'b0));
    plan_rows.push_back(pixel_row(4, 19, 16'hFFFF, 1'b0));
    plan_rows.push_back(pixel_row(4, 20, 16'hFFFF, 1'b1));
    plan_rows.push_back(word_row(lpw_pkg::CMD_LOAD, 0, 0, 2, 2));   // tie, x-major
    plan_rows.push_back(word_row(lpw_pkg::CMD_STEP, 0, 0, 0, 0));
    plan_rows.push_back(word_row(lpw_pkg::CMD_LOAD, 10, 10, 8, 4)); // reload mid-line, steep
    plan_rows.push_back(word_row(lpw_pkg::CMD_STEP, 0, 0, 0, 0));
    plan_rows.push_back(word_row(lpw_pkg::CMD_STEP, 0, 0, 0, 0));
    plan_rows.push_back(reg_row(lpw_pkg::REG_ORIENTATION, 16'h0001)); // change mid-line
    plan_rows.push_back(reg_row(lpw_pkg::REG_DRAW_COLOR, 16'h0000));
    plan_rows.push_back(reg_row(lpw_pkg::REG_SPARE_2, 16'h1234));     // ignored index
    plan_rows.push_back(word_row(lpw_pkg::CMD_STEP, 0, 0, 0, 0));
    plan_rows.push_back(word_row(lpw_pkg::CMD_LOAD, 0, 0, 0, 0));   // landscape flip
    plan_rows.push_back(pixel_row(0, MAX_COORD, 16'h0000, 1'b1));
    plan_rows.push_back(word_row(lpw_pkg::CMD_LOAD, MAX_COORD, MAX_COORD,
                                 MAX_COORD, MAX_COORD));
    plan_rows.push_back(pixel_row(MAX_COORD, 0, 16'h0000, 1'b1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan_rows[i]) begin
      if (plan_rows[i].kind == ROW_REG) begin
        if (i == 0 || plan_rows[i-1].kind != ROW_REG) settle();
        write_reg(plan_rows[i].reg_idx, plan_rows[i].reg_data);
        if (i == plan_rows.size() - 1 || plan_rows[i+1].kind != ROW_REG)
          cfg_valid <= 1'b0;
      end else begin
        send_word(plan_rows[i].word, plan_rows[i].typed, plan_rows[i].pixel);
      end
    end

    // random phases, each under its own register setting and pacing
    target = useful_words;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin orient = 1'b1; color = 16'h0000; end
        1: begin orient = 1'b0; color = 16'hFFFF; end
        default: begin
          orient = $urandom_range(0, 1);
          color  = lpw_pkg::color_t'($urandom_range(0, 65535));
        end
      endcase
      settle();
      write_reg(lpw_pkg::REG_ORIENTATION, lpw_pkg::color_t'(orient));
      write_reg(lpw_pkg::REG_DRAW_COLOR, color);
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? lpw_pkg::REG_SPARE_3 : lpw_pkg::REG_SPARE_2,
                  lpw_pkg::color_t'($urandom_range(0, 65535)));
      cfg_valid <= 1'b0;
      gap_pct   = (phase % 4 == 3) ? 0 : $urandom_range(5, 50);
      stall_pct = (phase % 4 == 3) ? 0 : $urandom_range(5, 50);
      target += RANDOM_WORDS / PHASES;
      while (useful_words < target) begin
        if ($urandom_range(0, 99) < 80) begin
          draw_random_line();
        end else begin
          // noise: any command, any content
          repeat ($urandom_range(1, 4))
            send_word(random_word(lpw_pkg::cmd_t'($urandom_range(0, 1))), 1'b0, '0);
        end
      end
    end

    // drain
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d words (%0d lines), checked %0d pixels, %0d register writes",
             words_sent, lines_loaded, pixels_checked, reg_writes);
    $display("covered both orientations, color extremes, reloads and idle steps");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
